@@ rtl/tpdd_pkg.sv @@
// Package for the tap position debounce decoder: sizes, register indexes,
// decode constants and the result record passed from the merge stage.
// No dependencies.
`default_nettype none

package tpdd_pkg;

   localparam int CHANNELS    = 10;
   localparam int PIN_W       = 10;
   localparam int DECODE_CHAN = 9;
   localparam int COUNT_W     = 16;
   localparam int TOTAL_W     = 5;
   localparam int MEM_W       = 5;
   localparam int POS_W       = 8;
   localparam int FAULT_DEPTH = 32;
   localparam int TOTAL_MAX   = (1 << TOTAL_W) - 1;
   localparam int SCAN_W      = TOTAL_MAX + 2;
   localparam int CHAN_W      = 4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_TOTAL = 1'd1;

   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET    = 5'd9;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 16'd1;

   localparam logic [TOTAL_W-1:0] TOTAL_FIVE      = 5'd5;
   localparam logic [TOTAL_W-1:0] TOTAL_NINE      = 5'd9;
   localparam logic [TOTAL_W-1:0] TOTAL_SEVENTEEN = 5'd17;

   localparam logic [POS_W-1:0] POS_NONE    = 8'd0;
   localparam logic [POS_W-1:0] POS_SEVERAL = 8'hff;

   typedef struct packed {
      logic [PIN_W-1:0] held_signals;
      logic [POS_W-1:0] position;
      logic             read_ok;
      logic             check_ok;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/tpdd_lane.sv @@
// One debounce lane: disagreement counter and held signal for one pin.
// Depends on tpdd_pkg.
`default_nettype none

module tpdd_lane
   import tpdd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               pin,
   input  wire logic [COUNT_W-1:0] debounce_ticks,
   output logic                    held_next
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               held_ff;
   logic               disagree;
   logic               expired;

   // held equal to the raw active-low level means the channel disagrees
   assign disagree  = (held_ff == pin);
   assign expired   = (count_ff >= debounce_ticks);
   assign held_next = (disagree && expired) ? ~pin : held_ff;

   always_comb begin
      count_in = count_ff;
      if (!disagree) begin
         count_in = '0;
      end else if (!expired) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         held_ff  <= 1'b0;
      end else if (advance) begin
         count_ff <= count_in;
         held_ff  <= held_next;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tpdd_merge.sv @@
// Merge stage: decodes the lanes' held signals into a position, keeps the
// fault map and runs the adjacent-fault check. Depends on tpdd_pkg.
`default_nettype none

module tpdd_merge
   import tpdd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [PIN_W-1:0]   held_next,
   input  wire logic [TOTAL_W-1:0] position_total,
   input  wire logic [MEM_W-1:0]   remembered_position,
   input  wire logic               do_check,
   output result_type              result
);

   logic [POS_W-1:0]       last_pos_ff, last_pos_in;
   logic [FAULT_DEPTH-1:0] fault_ff, fault_in;
   logic [SCAN_W-1:0]      scan;
   logic [DECODE_CHAN-1:0] active;
   logic [CHAN_W-1:0]      chan;
   logic                   none_active;
   logic                   many_active;
   logic                   read_ok;
   logic                   adjacent;

   assign active      = held_next[DECODE_CHAN-1:0];
   assign none_active = ~|active;
   assign many_active = |(active & (active - DECODE_CHAN'(1)));

   always_comb begin
      chan = '0;
      for (int k = 0; k < DECODE_CHAN; k++) begin
         if (active[k]) begin
            chan = CHAN_W'(k + 1);
         end
      end
   end

   always_comb begin
      last_pos_in = last_pos_ff;
      read_ok     = 1'b1;
      if (none_active) begin
         last_pos_in = POS_NONE;
         read_ok     = 1'b0;
      end else if (many_active) begin
         last_pos_in = POS_SEVERAL;
         read_ok     = 1'b0;
      end else if (position_total == TOTAL_FIVE) begin
         if (chan[0]) begin
            last_pos_in = POS_W'(chan >> 1) + POS_W'(1);
         end else begin
            read_ok = 1'b0;
         end
      end else if (position_total == TOTAL_NINE || position_total == TOTAL_SEVENTEEN) begin
         last_pos_in = POS_W'(chan);
      end else begin
         last_pos_in = POS_NONE;
      end
   end

   // write the mark first, then scan the updated map
   always_comb begin
      fault_in = fault_ff;
      for (int j = 0; j < FAULT_DEPTH; j++) begin
         if (do_check && (32'(remembered_position) == 32'(j))) begin
            fault_in[j] = ~read_ok;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < SCAN_W; j++) begin
         scan[j] = (j < FAULT_DEPTH) ? fault_in[j % FAULT_DEPTH] : 1'b0;
      end
   end

   always_comb begin
      adjacent = 1'b0;
      for (int i = 1; i <= TOTAL_MAX; i++) begin
         if ((TOTAL_W'(i) <= position_total) && scan[i] && (scan[i-1] || scan[i+1])) begin
            adjacent = 1'b1;
         end
      end
   end

   assign result.held_signals = held_next;
   assign result.position     = last_pos_in;
   assign result.read_ok      = read_ok;
   assign result.check_ok     = ~(do_check && adjacent);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= POS_NONE;
         fault_ff    <= '0;
      end else if (advance) begin
         last_pos_ff <= last_pos_in;
         fault_ff    <= fault_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tap_position_debounce_decoder_top.sv @@
// Channel     Direction  Handshake           Payload
// req         in         req_valid/req_stall raw_pins, remembered_position, do_check
// rsp         out        rsp_valid/rsp_stall held_signals, position, read_ok, check_ok
// csr         in         csr_write_enable    csr_index, csr_write_data
//
// One transaction per cycle while req_stall is low; its result reaches rsp
// the cycle after acceptance, later only while rsp_stall holds the output register.
// All lanes and the merge stage update in the cycle a transaction is taken,
// so the next transaction sees the new state with no bubble.
// Synchronous active-high reset clears lane counters to one, held signals,
// last position and the fault map; there is no clearing pass.
// An output register plus one skid entry part the sides: req_stall rises only
// while the skid entry is occupied.
//
// Top level of the tap position debounce decoder. Depends on tpdd_pkg,
// tpdd_lane and tpdd_merge.
`default_nettype none

module tap_position_debounce_decoder_top
   import tpdd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PIN_W-1:0]       req_raw_pins,
   input  wire logic [MEM_W-1:0]       req_remembered_position,
   input  wire logic                   req_do_check,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [PIN_W-1:0]            rsp_held_signals,
   output logic [POS_W-1:0]            rsp_position,
   output logic                        rsp_read_ok,
   output logic                        rsp_check_ok,
   // configuration
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [COUNT_W-1:0] debounce_ticks_ff;
   logic [TOTAL_W-1:0] position_total_ff;

   logic               accept;
   logic               out_free;
   logic [PIN_W-1:0]   held_next;
   result_type         result;

   result_type         out_ff;
   logic               out_valid_ff;
   result_type         skid_ff;
   logic               skid_valid_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RESET;
         position_total_ff <= TOTAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_write_data[COUNT_W-1:0];
            CSR_POSITION_TOTAL: position_total_ff <= csr_write_data[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Debounce lanes, one per pin; pins beyond CHANNELS hold zero
   for (genvar k = 0; k < PIN_W; k++) begin : g_lane
      if (k < CHANNELS) begin : g_on
         tpdd_lane u_lane (
            .clock          (clock),
            .reset          (reset),
            .advance        (accept),
            .pin            (req_raw_pins[k]),
            .debounce_ticks (debounce_ticks_ff),
            .held_next      (held_next[k])
         );
      end else begin : g_off
         assign held_next[k] = 1'b0;
      end
   end

   tpdd_merge u_merge (
      .clock               (clock),
      .reset               (reset),
      .advance             (accept),
      .held_next           (held_next),
      .position_total      (position_total_ff),
      .remembered_position (req_remembered_position),
      .do_check            (req_do_check),
      .result              (result)
   );

   // Output register and skid entry: drain the skid first, else load new result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_free) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_held_signals = out_ff.held_signals;
   assign rsp_position     = out_ff.position;
   assign rsp_read_ok      = out_ff.read_ok;
   assign rsp_check_ok     = out_ff.check_ok;

`ifndef SYNTHESIS
   // skid entry only fills behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while output register empty");

   // after an accepted transaction rsp_valid is always high next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no response");

   // a good read never reports the several-active code
   a_read_ok_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_ok) |-> (rsp_position != POS_SEVERAL))
      else $error("read_ok with several-active position");

   // a good read needs some decoded channel held
   a_read_ok_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_ok) |-> (rsp_held_signals[DECODE_CHAN-1:0] != '0))
      else $error("read_ok with no channel held");
`endif

endmodule

`default_nettype wire

@@ test/tap_position_debounce_decoder_top_tb.sv @@
// Self-checking bench for tap_position_debounce_decoder_top: per-pin debounce, tap decode,
// fault-map adjacency check, each transaction checked against an in-bench predictor.
// Depends on tpdd_pkg and the RTL of the decoder only.
`timescale 1ns / 100ps

module tap_position_debounce_decoder_top_tb;
   import tpdd_pkg::*;

   typedef struct {
      logic [PIN_W-1:0] pins;
      logic [MEM_W-1:0] mem;
      logic             chk;
   } tap_sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIN_W-1:0]       req_raw_pins = '1;
   logic [MEM_W-1:0]       req_remembered_position = '0;
   logic                   req_do_check = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIN_W-1:0]       rsp_held_signals;
   logic [POS_W-1:0]       rsp_position;
   logic                   rsp_read_ok;
   logic                   rsp_check_ok;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEBOUNCE_TICKS;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Bench copy of the decoder state and its two registers
   logic [COUNT_W-1:0] model_ticks;
   logic [TOTAL_W-1:0] model_total;
   logic [PIN_W-1:0]   model_held;
   logic [COUNT_W-1:0] model_count [CHANNELS];
   logic [POS_W-1:0]   model_last;
   logic [FAULT_DEPTH-1:0] model_fault;

   tap_sample_type pending_samples [$];
   result_type     expected_readings [$];
   tap_sample_type drive_sample;
   result_type     want;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;

   tap_position_debounce_decoder_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_raw_pins            (req_raw_pins),
      .req_remembered_position (req_remembered_position),
      .req_do_check            (req_do_check),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_held_signals        (rsp_held_signals),
      .rsp_position            (rsp_position),
      .rsp_read_ok             (rsp_read_ok),
      .rsp_check_ok            (rsp_check_ok),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   always #5 clock = ~clock;

   // Advance the bench state by one tick and return the reading it should produce.
   function automatic result_type predict_reading(tap_sample_type s);
      result_type r;
      int active;
      int chan;
      bit ok_read;
      bit ok_check;
      logic [FAULT_DEPTH:0] marks;
      active = 0;
      chan = 0;
      ok_read = 1'b1;
      ok_check = 1'b1;
      // Debounce: a held bit equal to the raw (active-low) level is disagreeing.
      for (int k = 0; k < CHANNELS; k++) begin
         if (model_held[k] == s.pins[k]) begin
            if (model_count[k] < model_ticks)
               model_count[k] = model_count[k] + 1'b1;
            else
               model_held[k] = ~s.pins[k];
         end else begin
            model_count[k] = '0;
         end
      end
      // Decode channels 1..9; channel 10 never takes part.
      for (int k = 0; k < DECODE_CHAN; k++) begin
         if (model_held[k]) begin
            active++;
            chan = k + 1;
         end
      end
      if (active == 0) begin
         model_last = POS_NONE;
         ok_read = 1'b0;
      end else if (active > 1) begin
         model_last = POS_SEVERAL;
         ok_read = 1'b0;
      end else if (model_total == TOTAL_FIVE) begin
         // even channel in five-position mode: hold the previous position
         if (chan % 2 == 0)
            ok_read = 1'b0;
         else
            model_last = POS_W'(chan / 2 + 1);
      end else if (model_total == TOTAL_NINE || model_total == TOTAL_SEVENTEEN) begin
         model_last = POS_W'(chan);
      end else begin
         model_last = POS_NONE;
      end
      // Mark first, then scan positions 1..total against both neighbours.
      if (s.chk) begin
         if (int'(s.mem) < FAULT_DEPTH)
            model_fault[s.mem] = ~ok_read;
         marks = {1'b0, model_fault};
         for (int i = 1; i <= int'(model_total); i++) begin
            if (marks[i] && (marks[i-1] || marks[i+1]))
               ok_check = 1'b0;
         end
      end
      r.held_signals = model_held;
      r.position     = model_last;
      r.read_ok      = ok_read;
      r.check_ok     = ok_check;
      return r;
   endfunction

   // Driver: predict each accepted transaction, then present the next pending sample.
   // Hold the payload while stalled; drop valid only on an idle draw or an empty queue.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_readings.push_back(predict_reading('{req_raw_pins,
               req_remembered_position, req_do_check}));
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_sample = pending_samples.pop_front();
               req_valid               <= 1'b1;
               req_raw_pins            <= drive_sample.pins;
               req_remembered_position <= drive_sample.mem;
               req_do_check            <= drive_sample.chk;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted response with the oldest predicted reading,
   // then draw the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("response transaction with no reading pending");
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_held_signals !== want.held_signals) begin
                  $error("held_signals: expected %h, got %h", want.held_signals,
                         rsp_held_signals);
                  error_count++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  error_count++;
               end
               if (rsp_read_ok !== want.read_ok) begin
                  $error("read_ok: expected %b, got %b", want.read_ok, rsp_read_ok);
                  error_count++;
               end
               if (rsp_check_ok !== want.check_ok) begin
                  $error("check_ok: expected %b, got %b", want.check_ok, rsp_check_ok);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Hold off until every queued sample is accepted and every reading has come back,
   // then let the pipeline settle.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_readings.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // Write both registers while the block is idle and mirror them in the bench.
   task automatic configure(input logic [COUNT_W-1:0] ticks,
                            input logic [TOTAL_W-1:0] total);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEBOUNCE_TICKS;
      csr_write_data   <= CSR_DATA_W'(ticks);
      @(posedge clock);
      csr_index        <= CSR_POSITION_TOTAL;
      csr_write_data   <= CSR_DATA_W'(total);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_ticks = ticks;
      model_total = total;
   endtask

   task automatic queue_one(input logic [PIN_W-1:0] pins, input logic [MEM_W-1:0] mem,
                            input logic chk);
      pending_samples.push_back('{pins, mem, chk});
   endtask

   // Hold a pin pattern long enough to pass the debounce, with the odd glitch
   // and random fault-map traffic on top.
   task automatic queue_patterns(input int n_items);
      logic [PIN_W-1:0] pattern;
      int hold;
      int added;
      added = 0;
      while (added < n_items) begin
         case ($urandom_range(9))
            0:       pattern = '1;
            1:       pattern = PIN_W'($urandom);
            default: pattern = ~(PIN_W'(1) << $urandom_range(PIN_W - 1));
         endcase
         hold = int'(model_ticks) + 1 + $urandom_range(3);
         repeat (hold) begin
            queue_one(($urandom_range(9) == 0) ? PIN_W'($urandom) : pattern,
                      MEM_W'($urandom), 1'($urandom_range(1)));
            added++;
         end
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] ticks;
      logic [TOTAL_W-1:0] total;

      model_ticks = DEBOUNCE_RESET;
      model_total = TOTAL_RESET;
      model_held  = '0;
      model_last  = POS_NONE;
      model_fault = '0;
      for (int k = 0; k < CHANNELS; k++)
         model_count[k] = COUNT_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 19;
      recv_idle_pct = 78;

      // Five-position mode, no debounce: none, odd and even channels, several,
      // channel ten alone, and a pair of adjacent faults.
      configure(16'd0, TOTAL_FIVE);
      queue_one(10'h3ff, 5'd0, 1'b1);
      queue_one(~10'h001, 5'd5, 1'b1);
      queue_one(~10'h002, 5'd2, 1'b1);
      queue_one(10'h3ff, 5'd1, 1'b1);
      queue_one(~10'h004, 5'd1, 1'b1);
      queue_one(10'h000, 5'd31, 1'b1);
      queue_one(~10'h200, 5'd3, 1'b0);
      queue_one(~10'h100, 5'd0, 1'b0);

      // Debounce of one: a one-tick glitch must not flip the held signals.
      configure(16'd1, TOTAL_SEVENTEEN);
      queue_one(~10'h040, 5'd7, 1'b1);
      queue_one(~10'h040, 5'd7, 1'b0);
      queue_one(~10'h040, 5'd7, 1'b1);
      queue_one(10'h3ff, 5'd16, 1'b1);
      queue_one(~10'h040, 5'd17, 1'b1);
      queue_one(~10'h040, 5'd7, 1'b1);

      // A total of 30, which is not decoded: faults at the top of the map.
      configure(16'd0, 5'd30);
      queue_one(10'h000, 5'd30, 1'b1);
      queue_one(10'h000, 5'd31, 1'b1);
      queue_one(~10'h010, 5'd31, 1'b1);

      // Longest debounce and a total of one: nothing can flip.
      configure(16'hffff, 5'd1);
      queue_one(10'h3ff, 5'd0, 1'b1);
      queue_one(10'h000, 5'd1, 1'b1);
      queue_one(~10'h001, 5'd1, 1'b1);
      queue_one(10'h2aa, 5'd2, 1'b0);

      // Random part in three idling regimes; each phase boundary also pauses
      // the sender until every reading is back.
      for (int g = 0; g < 3; g++) begin
         case (g)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int p = 0; p < 6; p++) begin
            case ($urandom_range(4))
               0, 1:    ticks = '0;
               2:       ticks = 16'd1;
               3:       ticks = 16'd2;
               default: ticks = COUNT_W'($urandom_range(6, 3));
            endcase
            case ($urandom_range(5))
               0:       total = TOTAL_FIVE;
               1:       total = TOTAL_NINE;
               2:       total = TOTAL_SEVENTEEN;
               3:       total = $urandom_range(1) ? 5'd30 : 5'd1;
               default: total = TOTAL_W'($urandom_range(30, 1));
            endcase
            configure(ticks, total);
            queue_patterns(45);
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tpdd_pkg.sv
rtl/tpdd_lane.sv
rtl/tpdd_merge.sv
rtl/tap_position_debounce_decoder_top.sv
test/tap_position_debounce_decoder_top_tb.sv
